// File: rtl/gray_scott_reaction_diffusion_stencil_assert.svh
// assertion macros for the gray-scott stencil
`ifndef GRAY_SCOTT_REACTION_DIFFUSION_STENCIL_ASSERT_SVH
`define GRAY_SCOTT_REACTION_DIFFUSION_STENCIL_ASSERT_SVH
`ifndef SYNTHESIS
`define GS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gray-scott stencil check failed");
`define GS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gray-scott stencil check failed");
`else
`define GS_ASSERT_NOW(label, ante, cons)
`define GS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/gsrd_pkg.sv
// shared constants and types of the gray-scott stencil
package gsrd_pkg;
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;
   localparam int VALUE_BITS_DEF = 16;

   localparam int COEF_BITS     = 16;
   localparam int SIZE_CFG_BITS = 11;
   localparam int CSR_IDX_BITS  = 3;
   localparam int MIN_SIZE      = 3;
   localparam int COEF_SHIFT    = 16;
   localparam int STEP_SHIFT    = 15;

   localparam logic [COEF_BITS-1:0]     T_MAX         = 16'd32768;
   localparam logic [COEF_BITS-1:0]     FEED_RESET    = 16'd1507;
   localparam logic [COEF_BITS-1:0]     KILL_RESET    = 16'd5046;
   localparam logic [COEF_BITS-1:0]     DIFF_U_RESET  = 16'd10486;
   localparam logic [COEF_BITS-1:0]     DIFF_V_RESET  = 16'd5243;
   localparam logic [COEF_BITS-1:0]     STEP_RESET    = 16'd32768;
   localparam logic [SIZE_CFG_BITS-1:0] WIDTH_RESET   = 11'd256;
   localparam logic [SIZE_CFG_BITS-1:0] HEIGHT_RESET  = 11'd256;

   localparam logic [CSR_IDX_BITS-1:0] CSR_FEED   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_KILL   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DIFF_U = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DIFF_V = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STEP   = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WIDTH  = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HEIGHT = 3'd6;

   typedef enum logic [1:0] {
      SHIFT_COEF,
      SHIFT_FRAC,
      SHIFT_STEP
   } shift_type;
endpackage

// File: rtl/gsrd_ram.sv
// generic simple dual-port ram with registered read
module gsrd_ram #(
   parameter int DATA_BITS = 32,
   parameter int DEPTH     = 3072
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_BITS-1:0]     wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_BITS-1:0]     rd_data_ff
);
   logic [DATA_BITS-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
endmodule

// File: rtl/gsrd_mul.sv
// shared sign-magnitude multiplier with selectable truncating shift
module gsrd_mul import gsrd_pkg::*; #(
   parameter int A_BITS    = 20,
   parameter int B_BITS    = 16,
   parameter int RES_BITS  = 22,
   parameter int FRAC_BITS = 15
) (
   input  logic                       clock,
   input  logic [A_BITS-1:0]          a_mag,
   input  logic [B_BITS-1:0]          b_op,
   input  shift_type                  shift_sel,
   input  logic                       negate,
   output logic signed [RES_BITS-1:0] res_ff
);
   localparam int P_BITS = A_BITS + B_BITS;

   logic [P_BITS-1:0]          prod;
   logic [P_BITS-1:0]          shifted;
   logic [RES_BITS-1:0]        mag_trunc;
   logic signed [RES_BITS-1:0] res_in;

   always_comb begin
      prod = P_BITS'(a_mag) * P_BITS'(b_op);
      case (shift_sel)
         SHIFT_COEF: shifted = prod >> COEF_SHIFT;
         SHIFT_FRAC: shifted = prod >> FRAC_BITS;
         SHIFT_STEP: shifted = prod >> STEP_SHIFT;
         default:    shifted = prod;
      endcase
      // truncation toward zero: shift the magnitude, then apply the sign
      mag_trunc = shifted[RES_BITS-1:0];
      res_in    = negate ? -$signed(mag_trunc) : $signed(mag_trunc);
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end
endmodule

// File: rtl/gray_scott_reaction_diffusion_stencil.sv
// top level of the streaming gray-scott reaction-diffusion stencil
// a request that emits nothing leaves req_stall low; border and interior cells hold req_stall after acceptance
// for the tap reads of the single read port and, for interior cells, the products of the shared multiplier
// the result is loaded at the edge where req_stall drops; a stalled result side adds its wait
// synchronous reset clears position and control and loads configuration defaults; line store is not cleared
module gray_scott_reaction_diffusion_stencil import gsrd_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [VALUE_BITS-1:0]         req_u_in,
   input  logic [VALUE_BITS-1:0]         req_v_in,
   input  logic                          req_frame_start,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [VALUE_BITS-1:0]         rsp_u_out,
   output logic [VALUE_BITS-1:0]         rsp_v_out,
   output logic [$clog2(MAX_WIDTH)-1:0]  rsp_out_col,
   output logic [$clog2(MAX_HEIGHT)-1:0] rsp_out_row,
   output logic                          rsp_is_border,
   output logic                          rsp_frame_done,
   // register write port
   input  logic                          csr_write,
   input  logic [CSR_IDX_BITS-1:0]       csr_index,
   input  logic [COEF_BITS-1:0]          csr_data
);
   localparam int V         = VALUE_BITS;
   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int ROW_BITS  = $clog2(MAX_HEIGHT);
   localparam int SZ_W      = $clog2(MAX_WIDTH + 1);
   localparam int SZ_H      = $clog2(MAX_HEIGHT + 1);
   localparam int ADDR_BITS = COL_BITS + 2;
   localparam int DEPTH     = 3 * (2 ** COL_BITS);
   localparam int MA        = V + 4;                           // multiplier magnitude input
   localparam int MB        = (V > COEF_BITS) ? V : COEF_BITS; // multiplier second input
   localparam int SW        = V + 6;                           // signed working width
   localparam int SUM_BITS  = V + 2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_MUL,
      S_SUM,
      S_STEP,
      S_OUT
   } state_type;

   state_type state_ff;

   // configuration registers
   logic [COEF_BITS-1:0]     feed_ff, kill_ff, diff_u_ff, diff_v_ff, step_ff;
   logic [SIZE_CFG_BITS-1:0] width_ff, height_ff;

   // stream position of the next cell and its slot in the three-row store
   logic [COL_BITS-1:0] col_ff;
   logic [ROW_BITS-1:0] row_ff;
   logic [1:0]          slot_ff;

   // emitted cell context
   logic [COL_BITS-1:0] c_ff;
   logic [ROW_BITS-1:0] r_ff;
   logic [1:0]          bot_ff, mid_ff, top_ff;
   logic                border_ff, done_ff;

   // sequencing counters
   logic [2:0] rd_cnt_ff;
   logic [2:0] op_cnt_ff;

   // datapath registers
   logic [V-1:0]         u_c_ff, v_c_ff;
   logic [SUM_BITS-1:0]  sum_u_ff, sum_v_ff;
   logic signed [SW-1:0] a_ff, b_ff, d2_ff, g_ff, kv_ff, su_ff, sv_ff, du_ff;
   logic [V-1:0]         nu_ff, nv_ff;

   // result register
   logic                rsp_valid_ff;
   logic [V-1:0]        rsp_u_ff, rsp_v_ff;
   logic [COL_BITS-1:0] rsp_col_ff;
   logic [ROW_BITS-1:0] rsp_row_ff;
   logic                rsp_border_ff, rsp_done_ff;

   // combinational decode
   logic                 accept, out_free;
   logic [SZ_W-1:0]      w_use;
   logic [SZ_H-1:0]      h_use;
   logic [COEF_BITS-1:0] t_use;
   logic [COL_BITS-1:0]  col_cur, col_in;
   logic [ROW_BITS-1:0]  row_cur, row_in;
   logic [1:0]           slot_cur, slot_in;
   logic                 emit, border_cur, done_cur;

   // line store access
   logic [ADDR_BITS-1:0] wr_addr, rd_addr;
   logic [2*V-1:0]       rd_data;
   logic [V-1:0]         rd_u, rd_v;

   // multiplier
   logic [MA-1:0]        mul_a;
   logic [MB-1:0]        mul_b;
   shift_type            mul_shift;
   logic                 mul_neg;
   logic signed [SW-1:0] mul_res;

   logic signed [SW-1:0] lap_u, lap_v, one_minus_u;
   logic [2:0]           rd_need;

   function automatic logic [MA-1:0] mag_of(input logic signed [SW-1:0] x);
      logic signed [SW-1:0] n;
      n = x[SW-1] ? -x : x;
      return n[MA-1:0];
   endfunction

   function automatic logic [V-1:0] clamp_val(input logic signed [SW-1:0] x);
      logic signed [SW-1:0] top;
      top = $signed(SW'({V{1'b1}}));
      if (x[SW-1]) begin
         return '0;
      end else if (x > top) begin
         return {V{1'b1}};
      end else begin
         return x[V-1:0];
      end
   endfunction

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // size and step clamping
   always_comb begin
      if (32'(width_ff) < MIN_SIZE) begin
         w_use = SZ_W'(MIN_SIZE);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_use = SZ_W'(MAX_WIDTH);
      end else begin
         w_use = SZ_W'(width_ff);
      end
      if (32'(height_ff) < MIN_SIZE) begin
         h_use = SZ_H'(MIN_SIZE);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_use = SZ_H'(MAX_HEIGHT);
      end else begin
         h_use = SZ_H'(height_ff);
      end
      t_use = (step_ff > T_MAX) ? T_MAX : step_ff;
   end

   // position of the arriving cell and raster advance
   always_comb begin
      col_cur  = req_frame_start ? '0 : col_ff;
      row_cur  = req_frame_start ? '0 : row_ff;
      slot_cur = req_frame_start ? '0 : slot_ff;

      emit = (row_cur != '0) && (col_cur != '0)
             && (32'(row_cur) < 32'(h_use)) && (32'(col_cur) < 32'(w_use));
      border_cur = (32'(row_cur) == 1) || (32'(col_cur) == 1);
      done_cur   = (32'(row_cur) + 1 == 32'(h_use)) && (32'(col_cur) + 1 == 32'(w_use));

      col_in  = col_cur;
      row_in  = row_cur;
      slot_in = slot_cur;
      if (32'(col_cur) + 1 >= 32'(w_use)) begin
         col_in = '0;
         if (32'(row_cur) + 1 >= 32'(h_use)) begin
            row_in  = '0;
            slot_in = '0;
         end else begin
            row_in  = row_cur + 1'b1;
            slot_in = (slot_cur == 2'd2) ? 2'd0 : slot_cur + 2'd1;
         end
      end else begin
         col_in = col_cur + 1'b1;
      end
   end

   // line store: write the arriving cell, read the stencil one tap a cycle
   assign wr_addr = {slot_cur, col_cur};
   assign rd_u    = rd_data[V-1:0];
   assign rd_v    = rd_data[2*V-1:V];
   assign rd_need = border_ff ? 3'd1 : 3'd5;

   always_comb begin
      case (rd_cnt_ff)
         3'd0:    rd_addr = {mid_ff, c_ff};
         3'd1:    rd_addr = {mid_ff, c_ff + 1'b1};
         3'd2:    rd_addr = {mid_ff, c_ff - 1'b1};
         3'd3:    rd_addr = {bot_ff, c_ff};
         3'd4:    rd_addr = {top_ff, c_ff};
         default: rd_addr = {mid_ff, c_ff};
      endcase
   end

   gsrd_ram #(
      .DATA_BITS (2 * V),
      .DEPTH     (DEPTH)
   ) u_line_store (
      .clock      (clock),
      .wr_en      (accept),
      .wr_addr    (wr_addr),
      .wr_data    ({req_v_in, req_u_in}),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   // laplacians and feed term from the gathered window
   assign lap_u       = $signed(SW'(sum_u_ff)) - $signed(SW'(u_c_ff) << 2);
   assign lap_v       = $signed(SW'(sum_v_ff)) - $signed(SW'(v_c_ff) << 2);
   assign one_minus_u = $signed(SW'(1) << (V - 1)) - $signed(SW'(u_c_ff));

   // operand selection for the shared multiplier
   always_comb begin
      mul_a     = '0;
      mul_b     = '0;
      mul_shift = SHIFT_COEF;
      mul_neg   = 1'b0;
      case (state_ff)
         S_MUL: begin
            case (op_cnt_ff)
               3'd0: begin // diffusion of u
                  mul_a   = mag_of(lap_u);
                  mul_b   = MB'(diff_u_ff);
                  mul_neg = lap_u[SW-1];
               end
               3'd1: begin // diffusion of v
                  mul_a   = mag_of(lap_v);
                  mul_b   = MB'(diff_v_ff);
                  mul_neg = lap_v[SW-1];
               end
               3'd2: begin // u*v
                  mul_a     = MA'(u_c_ff);
                  mul_b     = MB'(v_c_ff);
                  mul_shift = SHIFT_FRAC;
               end
               3'd3: begin // (u*v)*v, taking u*v straight from the multiplier
                  mul_a     = mul_res[MA-1:0];
                  mul_b     = MB'(v_c_ff);
                  mul_shift = SHIFT_FRAC;
               end
               3'd4: begin // feed term
                  mul_a   = mag_of(one_minus_u);
                  mul_b   = MB'(feed_ff);
                  mul_neg = one_minus_u[SW-1];
               end
               3'd5: begin // kill term
                  mul_a = MA'(v_c_ff);
                  mul_b = MB'(kill_ff);
               end
               default: begin
                  mul_a = '0;
               end
            endcase
         end
         S_STEP: begin
            mul_shift = SHIFT_STEP;
            mul_b     = MB'(t_use);
            if (op_cnt_ff == 3'd0) begin
               mul_a   = mag_of(su_ff);
               mul_neg = su_ff[SW-1];
            end else begin
               mul_a   = mag_of(sv_ff);
               mul_neg = sv_ff[SW-1];
            end
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   gsrd_mul #(
      .A_BITS    (MA),
      .B_BITS    (MB),
      .RES_BITS  (SW),
      .FRAC_BITS (V - 1)
   ) u_mul (
      .clock     (clock),
      .a_mag     (mul_a),
      .b_op      (mul_b),
      .shift_sel (mul_shift),
      .negate    (mul_neg),
      .res_ff    (mul_res)
   );

   // sequencer, registers and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         slot_ff      <= '0;
         rd_cnt_ff    <= '0;
         op_cnt_ff    <= '0;
         feed_ff      <= FEED_RESET;
         kill_ff      <= KILL_RESET;
         diff_u_ff    <= DIFF_U_RESET;
         diff_v_ff    <= DIFF_V_RESET;
         step_ff      <= STEP_RESET;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_FEED:   feed_ff   <= csr_data;
               CSR_KILL:   kill_ff   <= csr_data;
               CSR_DIFF_U: diff_u_ff <= csr_data;
               CSR_DIFF_V: diff_v_ff <= csr_data;
               CSR_STEP:   step_ff   <= csr_data;
               CSR_WIDTH:  width_ff  <= csr_data[SIZE_CFG_BITS-1:0];
               CSR_HEIGHT: height_ff <= csr_data[SIZE_CFG_BITS-1:0];
               default:    feed_ff   <= feed_ff;
            endcase
         end

         // drain the result register unless a new result is loaded below
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  col_ff  <= col_in;
                  row_ff  <= row_in;
                  slot_ff <= slot_in;
                  if (emit) begin
                     c_ff      <= col_cur - 1'b1;
                     r_ff      <= row_cur - 1'b1;
                     bot_ff    <= slot_cur;
                     mid_ff    <= (slot_cur == 2'd0) ? 2'd2 : slot_cur - 2'd1;
                     top_ff    <= (slot_cur == 2'd2) ? 2'd0 : slot_cur + 2'd1;
                     border_ff <= border_cur;
                     done_ff   <= done_cur;
                     rd_cnt_ff <= '0;
                     state_ff  <= S_READ;
                  end
               end
            end
            S_READ: begin
               rd_cnt_ff <= rd_cnt_ff + 3'd1;
               // data of tap rd_cnt-1 is on the read port now
               case (rd_cnt_ff)
                  3'd1: begin
                     u_c_ff <= rd_u;
                     v_c_ff <= rd_v;
                     nu_ff  <= rd_u;
                     nv_ff  <= rd_v;
                  end
                  3'd2: begin
                     sum_u_ff <= SUM_BITS'(rd_u);
                     sum_v_ff <= SUM_BITS'(rd_v);
                  end
                  3'd3, 3'd4, 3'd5: begin
                     sum_u_ff <= sum_u_ff + SUM_BITS'(rd_u);
                     sum_v_ff <= sum_v_ff + SUM_BITS'(rd_v);
                  end
                  default: begin
                     sum_u_ff <= sum_u_ff;
                  end
               endcase
               if (rd_cnt_ff == rd_need) begin
                  op_cnt_ff <= '0;
                  state_ff  <= border_ff ? S_OUT : S_MUL;
               end
            end
            S_MUL: begin
               op_cnt_ff <= op_cnt_ff + 3'd1;
               // product of op_cnt-1 is in the multiplier register
               case (op_cnt_ff)
                  3'd1:    a_ff  <= mul_res;
                  3'd2:    b_ff  <= mul_res;
                  3'd4:    d2_ff <= mul_res;
                  3'd5:    g_ff  <= mul_res;
                  3'd6:    kv_ff <= mul_res;
                  default: a_ff  <= a_ff;
               endcase
               if (op_cnt_ff == 3'd6) begin
                  state_ff <= S_SUM;
               end
            end
            S_SUM: begin
               su_ff     <= a_ff - d2_ff + g_ff;
               sv_ff     <= b_ff + d2_ff - kv_ff;
               op_cnt_ff <= '0;
               state_ff  <= S_STEP;
            end
            S_STEP: begin
               op_cnt_ff <= op_cnt_ff + 3'd1;
               if (op_cnt_ff == 3'd1) begin
                  du_ff <= mul_res;
               end
               if (op_cnt_ff == 3'd2) begin
                  nu_ff    <= clamp_val($signed(SW'(u_c_ff)) + du_ff);
                  nv_ff    <= clamp_val($signed(SW'(v_c_ff)) + mul_res);
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_u_ff      <= nu_ff;
                  rsp_v_ff      <= nv_ff;
                  rsp_col_ff    <= c_ff;
                  rsp_row_ff    <= r_ff;
                  rsp_border_ff <= border_ff;
                  rsp_done_ff   <= done_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_u_out      = rsp_u_ff;
   assign rsp_v_out      = rsp_v_ff;
   assign rsp_out_col    = rsp_col_ff;
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_is_border  = rsp_border_ff;
   assign rsp_frame_done = rsp_done_ff;

   `include "gray_scott_reaction_diffusion_stencil_assert.svh"

   // a finished cell always reaches the result register once the slot is free
   `GS_ASSERT_NEXT(out_loads_result, (state_ff == S_OUT) && out_free, (state_ff == S_IDLE) && rsp_valid_ff)
   // a taken result is not shown again unless a new one is loaded
   `GS_ASSERT_NEXT(result_drains, rsp_valid_ff && !rsp_stall && (state_ff != S_OUT), !rsp_valid_ff)
   // border cells bypass the arithmetic
   `GS_ASSERT_NOW(border_skips_math, (state_ff == S_MUL) || (state_ff == S_STEP), !border_ff)
endmodule
